### sv/held_key_tracker_unit_macros.svh
// ----------------------------------------------------------------------------
// Held key tracker assertion macros
// Concurrent assertion wrappers; define ASSERT_OFF to compile them away.
// ----------------------------------------------------------------------------
`ifndef HELD_KEY_TRACKER_UNIT_MACROS_SVH
`define HELD_KEY_TRACKER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

`define HKT_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("held_key_tracker_unit: assertion failed");

`define HKT_ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("held_key_tracker_unit: forbidden condition seen");

`else

`define HKT_ASSERT(lbl, clk, rst_n, prop)

`define HKT_ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

### sv/hkt_pkg.sv
// ----------------------------------------------------------------------------
// Held key tracker package
// Shared constants, word types and controller/datapath command and status types.
// ----------------------------------------------------------------------------
`default_nettype none

package hkt_pkg;

	localparam int TABLE_DEPTH_DEF = 32;

	localparam int MODE_W = 3;
	localparam int ID_W   = 16;
	localparam int PAY_W  = 32;
	localparam int TYPE_W = 2;
	localparam int ENTRY_W = 3 * ID_W;

	localparam logic [MODE_W-1:0] MODE_KEY    = 3'd0;
	localparam logic [MODE_W-1:0] MODE_MOUSE  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_TEXT   = 3'd2;
	localparam logic [MODE_W-1:0] MODE_RETIRE = 3'd3;

	localparam logic [TYPE_W-1:0] ETYPE_KEY = 2'd0;

	localparam logic KIND_FWD    = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	localparam logic ST_OK   = 1'b0;
	localparam logic ST_FULL = 1'b1;

	typedef enum logic [2:0] {
		EMIT_NONE,
		EMIT_KEY_IN,
		EMIT_PASS,
		EMIT_ENTRY,
		EMIT_STATUS
	} emit_sel_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [ID_W-1:0]   source_id;
		logic [ID_W-1:0]   hw_scan;
		logic [ID_W-1:0]   key_code;
		logic              is_press;
		logic [PAY_W-1:0]  payload;
		logic              vm_running;
	} evt_word_t;

	typedef struct packed {
		logic              item_kind;
		logic [TYPE_W-1:0] event_type;
		logic [ID_W-1:0]   out_source;
		logic [ID_W-1:0]   out_scan;
		logic [ID_W-1:0]   out_key;
		logic              out_press;
		logic [PAY_W-1:0]  out_payload;
		logic              status;
		logic              last;
	} res_word_t;

	typedef struct packed {
		logic      load_in;
		logic      idx_inc;
		logic      rd_en;
		logic      rd_last;
		logic      wr_append;
		logic      wr_remove;
		logic      cnt_inc;
		logic      cnt_dec;
		logic      set_full;
		emit_sel_t emit;
	} dp_cmd_t;

	typedef struct packed {
		logic is_retire;
		logic is_key;
		logic is_pass;
		logic run;
		logic press;
		logic idx_lt_cnt;
		logic cnt_full;
		logic key_match;
		logic src_match;
		logic out_free;
	} dp_sts_t;

endpackage

`default_nettype wire

### sv/hkt_evt_if.sv
// ----------------------------------------------------------------------------
// Held key tracker event channel
// Valid/ready channel carrying one input event word.
// ----------------------------------------------------------------------------
`default_nettype none

interface hkt_evt_if;
	import hkt_pkg::*;

	logic              valid;
	logic              ready;
	logic [MODE_W-1:0] mode;
	logic [ID_W-1:0]   source_id;
	logic [ID_W-1:0]   hw_scan;
	logic [ID_W-1:0]   key_code;
	logic              is_press;
	logic [PAY_W-1:0]  payload;
	logic              vm_running;

	modport source (
		output valid, mode, source_id, hw_scan, key_code, is_press, payload,
			vm_running,
		input  ready
	);

	modport sink (
		input  valid, mode, source_id, hw_scan, key_code, is_press, payload,
			vm_running,
		output ready
	);
endinterface

`default_nettype wire

### sv/hkt_res_if.sv
// ----------------------------------------------------------------------------
// Held key tracker result channel
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
`default_nettype none

interface hkt_res_if;
	import hkt_pkg::*;

	logic              valid;
	logic              ready;
	logic              item_kind;
	logic [TYPE_W-1:0] event_type;
	logic [ID_W-1:0]   out_source;
	logic [ID_W-1:0]   out_scan;
	logic [ID_W-1:0]   out_key;
	logic              out_press;
	logic [PAY_W-1:0]  out_payload;
	logic              status;
	logic              last;

	modport source (
		output valid, item_kind, event_type, out_source, out_scan, out_key, out_press,
			out_payload, status, last,
		input  ready
	);

	modport sink (
		input  valid, item_kind, event_type, out_source, out_scan, out_key, out_press,
			out_payload, status, last,
		output ready
	);
endinterface

`default_nettype wire

### sv/held_key_tracker_unit.sv
// Dropped events return to idle for the status word; pass-throughs first emit from the
// forward state. Key events scan the table entry by entry, swap-removing a matched release;
// source retire swap-removes each entry of its source, releasing it first when running.
// Throughput: one event at a time, the next taken the cycle after its status word is
// registered. Reset: held count and output valid clear, table undefined.
// ----------------------------------------------------------------------------
// Held key tracker unit
// Tracks held keys per source and forwards input events with a final status.
// ----------------------------------------------------------------------------
`default_nettype none

module held_key_tracker_unit #(
	parameter int TABLE_DEPTH = hkt_pkg::TABLE_DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	hkt_evt_if.sink   evt,
	hkt_res_if.source res
);
	import hkt_pkg::*;

	evt_word_t evt_word;
	res_word_t res_word;
	dp_cmd_t   cmd;
	dp_sts_t   sts;
	logic      res_valid;
	logic      evt_ready;

	assign evt_word.mode       = evt.mode;
	assign evt_word.source_id  = evt.source_id;
	assign evt_word.hw_scan    = evt.hw_scan;
	assign evt_word.key_code   = evt.key_code;
	assign evt_word.is_press   = evt.is_press;
	assign evt_word.payload    = evt.payload;
	assign evt_word.vm_running = evt.vm_running;
	assign evt.ready           = evt_ready;

	hkt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (evt.valid),
		.evt_ready (evt_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	hkt_dp #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_word  (evt_word),
		.cmd       (cmd),
		.sts       (sts),
		.res_word  (res_word),
		.res_valid (res_valid),
		.res_ready (res.ready)
	);

	assign res.valid       = res_valid;
	assign res.item_kind   = res_word.item_kind;
	assign res.event_type  = res_word.event_type;
	assign res.out_source  = res_word.out_source;
	assign res.out_scan    = res_word.out_scan;
	assign res.out_key     = res_word.out_key;
	assign res.out_press   = res_word.out_press;
	assign res.out_payload = res_word.out_payload;
	assign res.status      = res_word.status;
	assign res.last        = res_word.last;
endmodule

`default_nettype wire

### sv/hkt_dp.sv
// ----------------------------------------------------------------------------
// Held key tracker datapath
// Event register, held-key table memory, count, scan index, output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "held_key_tracker_unit_macros.svh"

module hkt_dp #(
	parameter int TABLE_DEPTH = hkt_pkg::TABLE_DEPTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire hkt_pkg::evt_word_t evt_word,
	input  wire hkt_pkg::dp_cmd_t  cmd,
	output hkt_pkg::dp_sts_t       sts,
	output hkt_pkg::res_word_t     res_word,
	output logic                   res_valid,
	input  wire logic              res_ready
);
	import hkt_pkg::*;

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	evt_word_t          evt_q;
	logic [CW-1:0]      idx_q;
	logic [CW-1:0]      cnt_q;
	logic [CW-1:0]      cnt_m1;
	logic               st_q;
	logic [ENTRY_W-1:0] rd_q;
	logic [ENTRY_W-1:0] mem [TABLE_DEPTH];
	logic [AW-1:0]      rd_addr;
	logic [ENTRY_W-1:0] key_ent;
	res_word_t          out_q;
	res_word_t          out_d;
	logic               out_valid_q;
	logic               out_free;
	logic               out_load;

	assign cnt_m1   = cnt_q - 1'b1;
	assign rd_addr  = cmd.rd_last ? cnt_m1[AW-1:0] : idx_q[AW-1:0];
	assign key_ent  = {evt_q.source_id, evt_q.hw_scan, evt_q.key_code};
	assign out_free = !out_valid_q || res_ready;
	assign out_load = out_free && (cmd.emit != EMIT_NONE);

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			evt_q <= evt_word;
			st_q  <= ST_OK;
		end else if (cmd.set_full) begin
			st_q <= ST_FULL;
		end
		if (cmd.rd_en) begin
			rd_q <= mem[rd_addr];
		end
		if (cmd.wr_append) begin
			mem[cnt_q[AW-1:0]] <= key_ent;
		end else if (cmd.wr_remove) begin
			mem[idx_q[AW-1:0]] <= rd_q;
		end
		if (out_load) begin
			out_q <= out_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (cmd.cnt_dec) begin
				cnt_q <= cnt_m1;
			end
			if (cmd.load_in) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		out_d = '0;
		case (cmd.emit)
			EMIT_KEY_IN: begin
				out_d.item_kind  = KIND_FWD;
				out_d.event_type = ETYPE_KEY;
				out_d.out_source = evt_q.source_id;
				out_d.out_scan   = evt_q.hw_scan;
				out_d.out_key    = evt_q.key_code;
				out_d.out_press  = evt_q.is_press;
			end
			EMIT_PASS: begin
				out_d.item_kind   = KIND_FWD;
				out_d.event_type  = evt_q.mode[TYPE_W-1:0];
				out_d.out_source  = evt_q.source_id;
				out_d.out_payload = evt_q.payload;
			end
			EMIT_ENTRY: begin
				out_d.item_kind  = KIND_FWD;
				out_d.event_type = ETYPE_KEY;
				{out_d.out_source, out_d.out_scan, out_d.out_key} = rd_q;
				out_d.out_press  = 1'b0;
			end
			EMIT_STATUS: begin
				out_d.item_kind = KIND_STATUS;
				out_d.status    = st_q;
				out_d.last      = 1'b1;
			end
			default: out_d = '0;
		endcase
	end

	always_comb begin
		sts.is_retire  = evt_q.mode == MODE_RETIRE;
		sts.is_key     = evt_q.mode == MODE_KEY;
		sts.is_pass    = (evt_q.mode == MODE_MOUSE) || (evt_q.mode == MODE_TEXT);
		sts.run        = evt_q.vm_running;
		sts.press      = evt_q.is_press;
		sts.idx_lt_cnt = idx_q < cnt_q;
		sts.cnt_full   = cnt_q == CW'(TABLE_DEPTH);
		sts.key_match  = rd_q == key_ent;
		sts.src_match  = rd_q[ENTRY_W-1 -: ID_W] == evt_q.source_id;
		sts.out_free   = out_free;
	end

	assign res_word  = out_q;
	assign res_valid = out_valid_q;

	`HKT_ASSERT_NEVER(a_cnt_bound, clk, arst_n, cnt_q > CW'(TABLE_DEPTH))
	`HKT_ASSERT(a_dec_nonempty, clk, arst_n, cmd.cnt_dec |-> (cnt_q != '0))
	`HKT_ASSERT(a_full_is_last, clk, arst_n, (out_valid_q && out_q.status) |-> out_q.last)
endmodule

`default_nettype wire

### sv/hkt_ctrl.sv
// ----------------------------------------------------------------------------
// Held key tracker controller
// Sequences table search, append, swap-removal and result emission.
// ----------------------------------------------------------------------------
`default_nettype none
`include "held_key_tracker_unit_macros.svh"

module hkt_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             evt_valid,
	output logic                  evt_ready,
	input  wire hkt_pkg::dp_sts_t sts,
	output hkt_pkg::dp_cmd_t      cmd
);
	import hkt_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_RD,
		S_CMP,
		S_EMIT_ENTRY,
		S_REM_RD,
		S_REM_WR,
		S_FWD
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   status_pend;
	// status_q marks the idle-state wait for the final status word
	logic   status_q;

	assign evt_ready   = (state_q == S_IDLE) && !status_pend;
	assign status_pend = status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			status_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE && status_q && sts.out_free) begin
				status_q <= 1'b0;
			end else if (state_q != S_IDLE && state_d == S_IDLE) begin
				status_q <= 1'b1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.emit = EMIT_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (status_q) begin
					if (sts.out_free) begin
						cmd.emit = EMIT_STATUS;
					end
				end else if (evt_valid) begin
					cmd.load_in = 1'b1;
					state_d     = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				if (sts.is_retire || (sts.run && sts.is_key)) begin
					state_d = S_RD;
				end else if (sts.run && sts.is_pass) begin
					state_d = S_FWD;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_RD: begin
				if (sts.idx_lt_cnt) begin
					cmd.rd_en = 1'b1;
					state_d   = S_CMP;
				end else if (sts.is_retire) begin
					state_d = S_IDLE;
				end else if (sts.press && sts.cnt_full) begin
					cmd.set_full = 1'b1;
					state_d      = S_IDLE;
				end else begin
					cmd.wr_append = sts.press;
					cmd.cnt_inc   = sts.press;
					state_d       = S_FWD;
				end
			end
			S_CMP: begin
				if (sts.is_retire) begin
					if (sts.src_match) begin
						state_d = sts.run ? S_EMIT_ENTRY : S_REM_RD;
					end else begin
						cmd.idx_inc = 1'b1;
						state_d     = S_RD;
					end
				end else if (sts.key_match) begin
					state_d = sts.press ? S_FWD : S_REM_RD;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = S_RD;
				end
			end
			S_EMIT_ENTRY: begin
				if (sts.out_free) begin
					cmd.emit = EMIT_ENTRY;
					state_d  = S_REM_RD;
				end
			end
			S_REM_RD: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_last = 1'b1;
				state_d     = S_REM_WR;
			end
			S_REM_WR: begin
				cmd.wr_remove = 1'b1;
				cmd.cnt_dec   = 1'b1;
				state_d       = sts.is_retire ? S_RD : S_FWD;
			end
			S_FWD: begin
				if (sts.out_free) begin
					cmd.emit = sts.is_key ? EMIT_KEY_IN : EMIT_PASS;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	`HKT_ASSERT(a_append_room, clk, arst_n, cmd.wr_append |-> !sts.cnt_full)
	`HKT_ASSERT(a_emit_free, clk, arst_n, (cmd.emit != EMIT_NONE) |-> sts.out_free)
	`HKT_ASSERT(a_remove_seq, clk, arst_n, cmd.wr_remove |-> $past(cmd.rd_en && cmd.rd_last))
endmodule

`default_nettype wire

### tb/tb.sv
// ----------------------------------------------------------------------------
// Held key tracker testbench
// Drives key, mouse, text, retire and other events into the tracker. A
// directed table covers field extremes and corner cases, then random traffic
// with table fill and drain passes follows. Every result word is checked against the
// row's typed words or an in-bench model of the held-key table. Both channels idle and
// stall at random, with one long output hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
	import hkt_pkg::*;

	localparam int DEPTH      = TABLE_DEPTH_DEF;
	localparam int NUM_EVENTS = 180;
	localparam int HOLD_CYC   = 300;
	localparam int DRAIN_CYC  = 20;

	localparam logic [MODE_W-1:0] MODE_OTHER = 3'd4;
	localparam logic [MODE_W-1:0] MODE_RSVD5 = 3'd5;
	localparam logic [MODE_W-1:0] MODE_RSVD6 = 3'd6;
	localparam logic [MODE_W-1:0] MODE_RSVD7 = 3'd7;

	localparam logic PRESS   = 1'b1;
	localparam logic RELEASE = 1'b0;
	localparam logic RUN_ON  = 1'b1;
	localparam logic RUN_OFF = 1'b0;

	typedef struct {
		evt_word_t ev;
		int        n_typed;
		res_word_t w0;
		res_word_t w1;
	} dir_row_t;

	logic clk;
	logic arst_n;

	hkt_evt_if evt_ch ();
	hkt_res_if res_ch ();

	held_key_tracker_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.evt    (evt_ch.sink),
		.res    (res_ch.source)
	);

	// held-key table as the block should see it
	logic [ID_W-1:0] tbl_src  [DEPTH];
	logic [ID_W-1:0] tbl_scan [DEPTH];
	logic [ID_W-1:0] tbl_key  [DEPTH];
	int              tbl_cnt;

	res_word_t step_words [$];
	res_word_t pending_words [$];
	dir_row_t  rows [$];
	logic [ID_W-1:0] src_pool [4];

	int  fail_cnt;
	int  events_sent;
	int  words_seen;
	int  full_seen;
	int  max_burst;
	bit  hold_req;
	bit  hold_done;
	bit  no_idle;
	bit  flood_done;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#20_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(25, 80);
	endfunction

	function automatic evt_word_t mk_evt(input logic [MODE_W-1:0] md, input logic [ID_W-1:0] src,
			input logic [ID_W-1:0] scan, input logic [ID_W-1:0] key, input logic press,
			input logic [PAY_W-1:0] pay, input logic run);
		evt_word_t ev;
		ev.mode       = md;
		ev.source_id  = src;
		ev.hw_scan    = scan;
		ev.key_code   = key;
		ev.is_press   = press;
		ev.payload    = pay;
		ev.vm_running = run;
		return ev;
	endfunction

	function automatic res_word_t key_word(input logic [ID_W-1:0] src,
			input logic [ID_W-1:0] scan, input logic [ID_W-1:0] key, input logic press);
		res_word_t w;
		w            = '0;
		w.item_kind  = KIND_FWD;
		w.event_type = ETYPE_KEY;
		w.out_source = src;
		w.out_scan   = scan;
		w.out_key    = key;
		w.out_press  = press;
		return w;
	endfunction

	function automatic res_word_t pass_word(input logic [MODE_W-1:0] md,
			input logic [ID_W-1:0] src, input logic [PAY_W-1:0] pay);
		res_word_t w;
		w             = '0;
		w.item_kind   = KIND_FWD;
		w.event_type  = md[TYPE_W-1:0];
		w.out_source  = src;
		w.out_payload = pay;
		return w;
	endfunction

	function automatic res_word_t status_word(input logic st);
		res_word_t w;
		w           = '0;
		w.item_kind = KIND_STATUS;
		w.status    = st;
		w.last      = 1'b1;
		return w;
	endfunction

	// swap-remove: last entry moves into the freed slot
	function automatic void drop_entry(input int i);
		tbl_cnt--;
		tbl_src[i]  = tbl_src[tbl_cnt];
		tbl_scan[i] = tbl_scan[tbl_cnt];
		tbl_key[i]  = tbl_key[tbl_cnt];
	endfunction

	task automatic track_event(input evt_word_t ev);
		int   i;
		logic st;
		step_words.delete();
		st = ST_OK;
		if (ev.mode == MODE_RETIRE) begin
			i = 0;
			while (i < tbl_cnt) begin
				if (tbl_src[i] != ev.source_id) begin
					i++;
				end else begin
					if (ev.vm_running)
						step_words.push_back(key_word(tbl_src[i], tbl_scan[i], tbl_key[i],
							RELEASE));
					drop_entry(i);
				end
			end
		end else if (ev.vm_running) begin
			if (ev.mode == MODE_KEY) begin
				for (i = 0; i < tbl_cnt; i++)
					if (tbl_src[i] == ev.source_id && tbl_scan[i] == ev.hw_scan &&
							tbl_key[i] == ev.key_code)
						break;
				if (ev.is_press) begin
					if (i == tbl_cnt) begin
						if (tbl_cnt >= DEPTH) begin
							st = ST_FULL;
						end else begin
							tbl_src[tbl_cnt]  = ev.source_id;
							tbl_scan[tbl_cnt] = ev.hw_scan;
							tbl_key[tbl_cnt]  = ev.key_code;
							tbl_cnt++;
						end
					end
					if (st == ST_OK)
						step_words.push_back(key_word(ev.source_id, ev.hw_scan, ev.key_code,
							PRESS));
				end else begin
					if (i < tbl_cnt)
						drop_entry(i);
					step_words.push_back(key_word(ev.source_id, ev.hw_scan, ev.key_code,
						RELEASE));
				end
			end else if (ev.mode == MODE_MOUSE || ev.mode == MODE_TEXT) begin
				step_words.push_back(pass_word(ev.mode, ev.source_id, ev.payload));
			end
		end
		step_words.push_back(status_word(st));
	endtask

	task automatic drive_fields(input evt_word_t ev);
		evt_ch.mode       <= ev.mode;
		evt_ch.source_id  <= ev.source_id;
		evt_ch.hw_scan    <= ev.hw_scan;
		evt_ch.key_code   <= ev.key_code;
		evt_ch.is_press   <= ev.is_press;
		evt_ch.payload    <= ev.payload;
		evt_ch.vm_running <= ev.vm_running;
	endtask

	task automatic send_evt(input evt_word_t ev, input int n_typed, input res_word_t w0,
			input res_word_t w1);
		int gap;
		gap = no_idle ? 0 : pick_gap();
		if (gap > 0) begin
			evt_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		evt_ch.valid <= 1'b1;
		drive_fields(ev);
		do
			@(posedge clk);
		while (!evt_ch.ready);
		events_sent++;
		track_event(ev);
		if (step_words.size() > max_burst)
			max_burst = step_words.size();
		if (n_typed == 0) begin
			foreach (step_words[k])
				pending_words.push_back(step_words[k]);
		end else begin
			pending_words.push_back(w0);
			if (n_typed > 1)
				pending_words.push_back(w1);
		end
	endtask

	task automatic send_random_evt();
		int               r;
		int               i;
		logic [MODE_W-1:0] md;
		logic [ID_W-1:0]  src;
		logic [ID_W-1:0]  scan;
		logic [ID_W-1:0]  key;
		logic             press;
		logic             run;
		r     = $urandom_range(0, 99);
		run   = ($urandom_range(0, 7) != 0);
		src   = ($urandom_range(0, 4) == 0) ? ID_W'($urandom_range(0, 16'hFFFF))
			: src_pool[$urandom_range(0, 3)];
		scan  = ID_W'($urandom_range(0, 16'hFFFF));
		key   = ID_W'($urandom_range(0, 16'hFFFF));
		press = 1'($urandom_range(0, 1));
		if (r < 60) begin
			md = MODE_KEY;
			if (tbl_cnt > 0 && $urandom_range(0, 99) < (press ? 20 : 70)) begin
				i    = $urandom_range(0, tbl_cnt - 1);
				src  = tbl_src[i];
				scan = tbl_scan[i];
				key  = tbl_key[i];
			end
		end else if (r < 75) begin
			md = $urandom_range(0, 1) ? MODE_MOUSE : MODE_TEXT;
		end else if (r < 87) begin
			md = MODE_RETIRE;
			if (tbl_cnt > 0 && $urandom_range(0, 1))
				src = tbl_src[$urandom_range(0, tbl_cnt - 1)];
		end else begin
			md = MODE_W'($urandom_range(MODE_OTHER, MODE_RSVD7));
		end
		send_evt(mk_evt(md, src, scan, key, press, $urandom, run), 0, '0, '0);
	endtask

	// empty the table, fill it to the top, press new and held keys into the full table, retire
	task automatic fill_and_retire(input bit one_source);
		logic [ID_W-1:0] src;
		int              k;
		while (tbl_cnt > 0)
			send_evt(mk_evt(MODE_RETIRE, tbl_src[0], ID_W'($urandom), ID_W'($urandom),
				1'($urandom), $urandom, RUN_ON), 0, '0, '0);
		if (one_source)
			hold_req = 1'b1;
		while (tbl_cnt < DEPTH) begin
			src = one_source ? src_pool[0] : src_pool[$urandom_range(0, 3)];
			send_evt(mk_evt(MODE_KEY, src, ID_W'($urandom), ID_W'($urandom), PRESS, $urandom,
				RUN_ON), 0, '0, '0);
		end
		for (k = 0; k < 2; k++)
			send_evt(mk_evt(MODE_KEY, src_pool[k], ID_W'($urandom), ID_W'($urandom), PRESS,
				$urandom, RUN_ON), 0, '0, '0);
		k = $urandom_range(0, DEPTH - 1);
		send_evt(mk_evt(MODE_KEY, tbl_src[k], tbl_scan[k], tbl_key[k], PRESS, $urandom,
			RUN_ON), 0, '0, '0);
		for (k = 0; k < 4; k++)
			send_evt(mk_evt(MODE_RETIRE, src_pool[k], ID_W'($urandom), ID_W'($urandom),
				1'($urandom), $urandom, (!one_source && k == 1) ? RUN_OFF : RUN_ON),
				0, '0, '0);
	endtask

	task automatic add_row(input evt_word_t ev, input int n_typed, input res_word_t w0,
			input res_word_t w1);
		dir_row_t row;
		row.ev      = ev;
		row.n_typed = n_typed;
		row.w0      = w0;
		row.w1      = w1;
		rows.push_back(row);
	endtask

	task automatic cmp_field(input string fname, input logic [PAY_W-1:0] want,
			input logic [PAY_W-1:0] got);
		if (want !== got) begin
			$error("%s: expected %h, got %h", fname, want, got);
			fail_cnt++;
		end
	endtask

	task automatic check_word();
		res_word_t act;
		res_word_t want_w;
		act.item_kind   = res_ch.item_kind;
		act.event_type  = res_ch.event_type;
		act.out_source  = res_ch.out_source;
		act.out_scan    = res_ch.out_scan;
		act.out_key     = res_ch.out_key;
		act.out_press   = res_ch.out_press;
		act.out_payload = res_ch.out_payload;
		act.status      = res_ch.status;
		act.last        = res_ch.last;
		words_seen++;
		if (act.item_kind == KIND_STATUS && act.status == ST_FULL)
			full_seen++;
		if (pending_words.size() == 0) begin
			$error("unexpected word: item_kind %0d source %h", act.item_kind, act.out_source);
			fail_cnt++;
		end else begin
			want_w = pending_words.pop_front();
			cmp_field("item_kind", PAY_W'(want_w.item_kind), PAY_W'(act.item_kind));
			cmp_field("event_type", PAY_W'(want_w.event_type), PAY_W'(act.event_type));
			cmp_field("out_source", PAY_W'(want_w.out_source), PAY_W'(act.out_source));
			cmp_field("out_scan", PAY_W'(want_w.out_scan), PAY_W'(act.out_scan));
			cmp_field("out_key", PAY_W'(want_w.out_key), PAY_W'(act.out_key));
			cmp_field("out_press", PAY_W'(want_w.out_press), PAY_W'(act.out_press));
			cmp_field("out_payload", want_w.out_payload, act.out_payload);
			cmp_field("status", PAY_W'(want_w.status), PAY_W'(act.status));
			cmp_field("last", PAY_W'(want_w.last), PAY_W'(act.last));
		end
	endtask

	// result side: random stalls, one long hold-off
	initial begin
		int stall_left;
		stall_left = 0;
		res_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (res_ch.valid && res_ch.ready)
				check_word();
			if (hold_req && !hold_done) begin
				res_ch.ready <= 1'b0;
				repeat (HOLD_CYC) @(posedge clk);
				hold_done = 1'b1;
			end else if (no_idle) begin
				res_ch.ready <= 1'b1;
			end else if (stall_left > 0) begin
				res_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				res_ch.ready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					stall_left = pick_gap();
			end
		end
	end

	initial begin
		int n_dir;
		arst_n       = 1'b0;
		evt_ch.valid <= 1'b0;
		drive_fields('0);
		tbl_cnt     = 0;
		fail_cnt    = 0;
		events_sent = 0;
		words_seen  = 0;
		full_seen   = 0;
		max_burst   = 0;
		hold_req    = 1'b0;
		hold_done   = 1'b0;
		no_idle     = 1'b0;
		flood_done  = 1'b0;
		foreach (src_pool[k])
			src_pool[k] = ID_W'($urandom_range(0, 16'hFFFF));

		add_row(mk_evt(MODE_MOUSE, 16'h0000, 16'hFFFF, 16'hFFFF, PRESS, 32'h0, RUN_ON), 2,
			pass_word(MODE_MOUSE, 16'h0000, 32'h0), status_word(ST_OK));
		add_row(mk_evt(MODE_TEXT, 16'hFFFF, 16'h0, 16'h0, RELEASE, 32'hFFFF_FFFF, RUN_ON), 2,
			pass_word(MODE_TEXT, 16'hFFFF, 32'hFFFF_FFFF), status_word(ST_OK));
		add_row(mk_evt(MODE_OTHER, 16'hFFFF, 16'hFFFF, 16'hFFFF, PRESS, 32'hFFFF_FFFF,
			RUN_ON), 1, status_word(ST_OK), '0);
		add_row(mk_evt(MODE_RSVD5, 16'h1, 16'h2, 16'h3, PRESS, 32'h5, RUN_ON), 1,
			status_word(ST_OK), '0);
		add_row(mk_evt(MODE_RSVD6, 16'h0, 16'h0, 16'h0, RELEASE, 32'h0, RUN_ON), 1,
			status_word(ST_OK), '0);
		add_row(mk_evt(MODE_RSVD7, 16'hFFFF, 16'hFFFF, 16'hFFFF, PRESS, 32'hFFFF_FFFF,
			RUN_ON), 1, status_word(ST_OK), '0);
		// release of a key nobody holds still goes out
		add_row(mk_evt(MODE_KEY, 16'h1, 16'h2, 16'h3, RELEASE, 32'h0, RUN_ON), 2,
			key_word(16'h1, 16'h2, 16'h3, RELEASE), status_word(ST_OK));
		add_row(mk_evt(MODE_KEY, 16'hFFFF, 16'hFFFF, 16'hFFFF, PRESS, 32'h0, RUN_ON), 2,
			key_word(16'hFFFF, 16'hFFFF, 16'hFFFF, PRESS), status_word(ST_OK));
		add_row(mk_evt(MODE_KEY, 16'hFFFF, 16'hFFFF, 16'hFFFF, PRESS, 32'h0, RUN_ON), 2,
			key_word(16'hFFFF, 16'hFFFF, 16'hFFFF, PRESS), status_word(ST_OK));
		add_row(mk_evt(MODE_KEY, 16'hFFFF, 16'h0, 16'h0, PRESS, 32'h0, RUN_ON), 0, '0, '0);
		add_row(mk_evt(MODE_KEY, 16'h0, 16'hFFFF, 16'h1, PRESS, 32'hFFFF_FFFF, RUN_ON), 0,
			'0, '0);
		add_row(mk_evt(MODE_KEY, 16'hFFFF, 16'h5, 16'h6, PRESS, 32'h0, RUN_ON), 0, '0, '0);
		add_row(mk_evt(MODE_KEY, 16'h0, 16'h0, 16'hFFFF, PRESS, 32'h0, RUN_ON), 0, '0, '0);
		add_row(mk_evt(MODE_MOUSE, 16'h9, 16'h0, 16'h0, RELEASE, 32'h1234_5678, RUN_OFF), 1,
			status_word(ST_OK), '0);
		add_row(mk_evt(MODE_KEY, 16'h7, 16'h7, 16'h7, PRESS, 32'h0, RUN_OFF), 1,
			status_word(ST_OK), '0);
		add_row(mk_evt(MODE_KEY, 16'hFFFF, 16'hFFFF, 16'hFFFF, RELEASE, 32'h0, RUN_OFF), 1,
			status_word(ST_OK), '0);
		add_row(mk_evt(MODE_KEY, 16'hFFFF, 16'h0, 16'h0, RELEASE, 32'h0, RUN_ON), 0, '0, '0);
		add_row(mk_evt(MODE_RETIRE, 16'hFFFF, 16'h0, 16'h0, RELEASE, 32'h0, RUN_ON), 0,
			'0, '0);
		// retire while halted drops entries without releases
		add_row(mk_evt(MODE_RETIRE, 16'h0, 16'h0, 16'h0, RELEASE, 32'h0, RUN_OFF), 1,
			status_word(ST_OK), '0);
		add_row(mk_evt(MODE_RETIRE, 16'h0, 16'hFFFF, 16'hFFFF, PRESS, 32'h0, RUN_ON), 1,
			status_word(ST_OK), '0);
		add_row(mk_evt(MODE_KEY, 16'h1, 16'h2, 16'h3, PRESS, 32'h0, RUN_ON), 0, '0, '0);
		add_row(mk_evt(MODE_TEXT, 16'h1, 16'h0, 16'h0, RELEASE, 32'hA5A5_5A5A, RUN_OFF), 1,
			status_word(ST_OK), '0);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[k])
			send_evt(rows[k].ev, rows[k].n_typed, rows[k].w0, rows[k].w1);
		n_dir = events_sent;

		while (events_sent < NUM_EVENTS) begin
			if (events_sent >= n_dir + 20 && !hold_req) begin
				fill_and_retire(1'b1);
			end else if (events_sent >= n_dir + 90 && !flood_done) begin
				flood_done = 1'b1;
				no_idle    = 1'b1;
				fill_and_retire(1'b0);
				no_idle    = 1'b0;
			end else begin
				send_random_evt();
			end
		end
		evt_ch.valid <= 1'b0;

		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);

		$display("Sent %0d events (%0d directed), checked %0d result words.",
			events_sent, n_dir, words_seen);
		$display("Table-full refusals: %0d, longest burst: %0d words, output hold: %0d cycles.",
			full_seen, max_burst, HOLD_CYC);
		if (fail_cnt == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule

`default_nettype wire

### filelist.f
+incdir+sv
sv/hkt_pkg.sv
sv/hkt_evt_if.sv
sv/hkt_res_if.sv
sv/hkt_dp.sv
sv/hkt_ctrl.sv
sv/held_key_tracker_unit.sv
tb/tb.sv
